// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants of the sorted priority queue
// Capacity, request and status codes, and the entry and control records
// that pass between the queue top level and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

   // number of cells in the chain
   localparam int CAPACITY = 16;
   // width of the fill count, which must hold CAPACITY itself
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // request codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // one stored entry
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] priority_key;
   } entry_type;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type new_entry;
   } ctl_type;

endpackage

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted shift chain
// Holds one entry. On insert it keeps its entry, takes the new one or takes
// its left neighbour's; on remove it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic               clock,
   input  spq_pkg::ctl_type   ctl,
   input  logic               occupied,
   input  logic               left_keep,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               keep,
   output spq_pkg::entry_type entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // stored entry stays where it is when it sorts at or before the new one
   assign keep = occupied && (entry_ff.priority_key <= ctl.new_entry.priority_key);

   // next entry of this slot
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in = ctl.new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctl.remove) begin
         entry_in = right_entry;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: sv/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue - bounded min-first priority queue
// Entries held in ascending priority order in a chain of identical cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising clock edge with start high and busy low.
//   req_cmd selects insert or remove; req_data_value and req_priority_req
//   carry the entry on insert and are ignored on remove. Insert places the
//   entry after every stored entry of lower or equal priority.
//   Every request gives one response in the cycle after it is taken, from the
//   response registers: rsp_strobe is high for that single cycle with
//   rsp_status, rsp_removed_value and rsp_now_empty. The receiver cannot stall,
//   so no response is ever held. Throughput is one request per cycle while busy
//   is low: all cells compare the new priority in parallel and each cell shifts,
//   keeps or loads in the same cycle.
//   busy is high only while reset is high. Reset empties the queue at once
//   (fill count to zero); cell contents are left as they are and are never
//   read before being written.
//   A full queue answers insert with status full, an empty queue answers
//   remove with status empty; the queue is unchanged in both cases.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic signed [31:0] req_data_value,
   input  logic signed [31:0] req_priority_req,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic               rsp_now_empty
);
   import spq_pkg::*;

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               strobe_ff;
   logic [1:0]         status_ff;
   logic [1:0]         status_in;
   logic signed [31:0] removed_ff;
   logic signed [31:0] removed_in;
   logic               now_empty_ff;

   logic      accept;
   logic      full;
   logic      empty;
   ctl_type   ctl;
   logic      keep  [CAPACITY];
   logic      occ   [CAPACITY];
   entry_type cells [CAPACITY];

   // handshake
   assign busy   = reset;
   assign accept = start && !busy;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // broadcast control for the chain
   always_comb begin
      ctl.insert                 = accept && (req_cmd == CMD_INSERT) && !full;
      ctl.remove                 = accept && (req_cmd == CMD_REMOVE) && !empty;
      ctl.new_entry.value        = req_data_value;
      ctl.new_entry.priority_key = req_priority_req;
   end

   // chain of cells, occupancy from the fill count
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occ[i]),
            .left_keep   (1'b1),
            .left_entry  (ctl.new_entry),
            .right_entry (cells[i+1]),
            .keep        (keep[i]),
            .entry       (cells[i])
         );
      end else if (i == CAPACITY - 1) begin : g_last
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occ[i]),
            .left_keep   (keep[i-1]),
            .left_entry  (cells[i-1]),
            .right_entry (cells[i]),
            .keep        (keep[i]),
            .entry       (cells[i])
         );
      end else begin : g_mid
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (occ[i]),
            .left_keep   (keep[i-1]),
            .left_entry  (cells[i-1]),
            .right_entry (cells[i+1]),
            .keep        (keep[i]),
            .entry       (cells[i])
         );
      end
   end

   // fill count and response contents
   always_comb begin
      count_in   = count_ff;
      status_in  = STATUS_OK;
      removed_in = '0;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove) begin
         count_in   = count_ff - CNT_W'(1);
         removed_in = cells[0].value;
      end
      if (accept && (req_cmd == CMD_INSERT) && full) begin
         status_in = STATUS_FULL;
      end else if (accept && (req_cmd == CMD_REMOVE) && empty) begin
         status_in = STATUS_EMPTY;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         removed_ff   <= removed_in;
         now_empty_ff <= (count_in == '0);
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_now_empty     = now_empty_ff;

   // every accepted request gives exactly one response in the next cycle
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_strobe == $past(accept)))
      else $error("response strobe does not follow accepted request");

   // fill count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   // insert into a full queue reports full and leaves the count alone
   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_INSERT) && full |=>
         (rsp_status == STATUS_FULL) && (count_ff == $past(count_ff)))
      else $error("insert into full queue mishandled");

   // head of the chain is in order
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cells[0].priority_key <= cells[1].priority_key))
      else $error("head entries out of priority order");

endmodule
